// File: sv/rfsm_pkg.sv
// Shared types and constants for the range to file segment mapper.
package rfsm_pkg;

    // Fixed field widths of the stream payloads.
    localparam int OP_W         = 2;
    localparam int FIELD_W      = 48;
    localparam int SEG_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 152;
    localparam int OUT_TDATA_W  = 200;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 63;
    localparam int DEF_INDEX_BITS   = 48;

    // Operation codes of an input transfer; the fourth code is ignored.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    // Status codes of a result transfer.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_QUERY,
        S_SCAN,
        S_ISSUE,
        S_BASE,
        S_CALC,
        S_PUT,
        S_SP_EMPTY,
        S_SP_MISS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    take_item;
        logic    scan_init;
        logic    scan_step;
        logic    emit_init;
        logic    ptr_inc;
        logic    load_base;
        logic    emit_calc;
        logic    emit_put;
        logic    seg_inc;
        logic    special_put;
        status_t special_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic range_inverted;
        logic table_short;
        logic scan_found;
        logic scan_miss;
        logic out_free;
        logic at_lseg;
    } sts_t;

endpackage

// File: sv/range_to_file_segment_mapper_unit.sv
// Top level of the range to file segment mapper: controller plus datapath.
// The block holds a table of up to MAX_SEGMENTS+1 cumulative boundaries in one
// memory with a single read port. Clear and append transfers complete when
// accepted and the block is ready again in the next cycle. A query is decoded,
// then the block scans one boundary per cycle until the segment holding the
// last wanted element is found, fetches the first segment's bounds (ISSUE,
// BASE), and computes each result (CALC) and loads it (PUT), waiting there
// while the result side is busy; inverted or unmatched ranges give a single
// status result after the decode or the scan. For the default table of 64
// boundaries the worst-case query time is set by the memory read port that
// both the scan and the result loop walk through. The block takes one input
// transfer at a time; the finished result register lets the next transfer be
// accepted while the last result still waits. The table contents are undefined
// until appended, and reset only empties the count.
module range_to_file_segment_mapper_unit #(
    parameter int MAX_SEGMENTS = rfsm_pkg::DEF_MAX_SEGMENTS,
    parameter int INDEX_BITS   = rfsm_pkg::DEF_INDEX_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0], boundary_value[49:2], range_first[97:50],
    // range_last[145:98], zero fill above.
    input  logic [rfsm_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // segment_index[5:0], first_in_segment[53:6], last_in_segment[101:54],
    // offset_before[149:102], used_count[197:150], zero fill above.
    output logic [rfsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status[1:0].
    output logic [rfsm_pkg::STATUS_W-1:0]     m_tuser,
    output logic                              m_tlast
);

    import rfsm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing of each transfer.
    rfsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table storage, arithmetic and result register.
    rfsm_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sv/rfsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rfsm_ctrl.sv
// Controller state machine that sequences clear, append and query operations.
module rfsm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rfsm_pkg::sts_t sts,
    output rfsm_pkg::cmd_t cmd
);

    import rfsm_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_item = 1'b1;
                    if (sts.op == OP_QUERY) begin
                        state_next = S_QUERY;
                    end
                end
            end
            S_QUERY: begin
                if (sts.range_inverted) begin
                    state_next = S_SP_EMPTY;
                end else if (sts.table_short) begin
                    state_next = S_SP_MISS;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_found) begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_ISSUE;
                end else if (sts.scan_miss) begin
                    state_next = S_SP_MISS;
                end
            end
            S_ISSUE: begin
                cmd.ptr_inc = 1'b1;
                state_next  = S_BASE;
            end
            S_BASE: begin
                cmd.load_base = 1'b1;
                cmd.ptr_inc   = 1'b1;
                state_next    = S_CALC;
            end
            S_CALC: begin
                cmd.emit_calc = 1'b1;
                state_next    = S_PUT;
            end
            S_PUT: begin
                if (sts.out_free) begin
                    cmd.emit_put = 1'b1;
                    if (sts.at_lseg) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.seg_inc = 1'b1;
                        cmd.ptr_inc = 1'b1;
                        state_next  = S_CALC;
                    end
                end
            end
            S_SP_EMPTY: begin
                if (sts.out_free) begin
                    cmd.special_put    = 1'b1;
                    cmd.special_status = STAT_EMPTY;
                    state_next         = S_IDLE;
                end
            end
            S_SP_MISS: begin
                if (sts.out_free) begin
                    cmd.special_put    = 1'b1;
                    cmd.special_status = STAT_NOT_FOUND;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rfsm_dp.sv
// Datapath: boundary memory, scan and emit arithmetic, and the result register.
module rfsm_dp #(
    parameter int MAX_SEGMENTS = 63,
    parameter int INDEX_BITS   = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rfsm_pkg::cmd_t                     cmd,
    output rfsm_pkg::sts_t                     sts,
    input  logic [rfsm_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [rfsm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [rfsm_pkg::STATUS_W-1:0]      m_tuser,
    output logic                               m_tlast
);

    import rfsm_pkg::*;

    localparam int DEPTH = MAX_SEGMENTS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;

    // Input fields.
    op_t         in_op;
    logic [IW-1:0] in_boundary;
    logic [IW-1:0] in_first;
    logic [IW-1:0] in_last;

    assign in_op       = op_t'(s_tdata[OP_W-1:0]);
    assign in_boundary = IW'(s_tdata[OP_W +: FIELD_W]);
    assign in_first    = IW'(s_tdata[OP_W + FIELD_W +: FIELD_W]);
    assign in_last     = IW'(s_tdata[OP_W + 2*FIELD_W +: FIELD_W]);

    // Control registers.
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] seg_reg, seg_next;
    logic [CW-1:0] fseg_reg, fseg_next;
    logic [CW-1:0] lseg_reg, lseg_next;
    logic          vld_reg, vld_next;
    logic          got_first_reg, got_first_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [IW-1:0]    first_reg, first_next;
    logic [IW-1:0]    last_reg, last_next;
    logic [IW-1:0]    start_reg, start_next;
    logic [IW-1:0]    fi_reg, fi_next;
    logic [IW-1:0]    lap1_reg, lap1_next;
    logic [IW-1:0]    off_reg, off_next;
    logic [SEG_W-1:0] out_seg_reg, out_seg_next;
    logic [IW-1:0]    out_fi_reg, out_fi_next;
    logic [IW-1:0]    out_la_reg, out_la_next;
    logic [IW-1:0]    out_off_reg, out_off_next;
    logic [IW-1:0]    out_cnt_reg, out_cnt_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    // Memory signals.
    logic          ram_we;
    logic [IW-1:0] rdata;
    logic          table_full;
    logic          gt_first;
    logic          gt_last;
    logic [CW-1:0] count_m2;
    logic [CW-1:0] fseg_fin;

    assign table_full = (count_reg >= CW'(DEPTH));
    assign ram_we     = cmd.take_item && (in_op == OP_APPEND) && !table_full;

    // Boundary table; read address follows the pointer register.
    rfsm_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_boundary),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Scan compares against the boundary that just came out of the memory.
    assign gt_first = (rdata > first_reg);
    assign gt_last  = (rdata > last_reg);
    assign count_m2 = count_reg - CW'(2);
    assign fseg_fin = got_first_reg ? fseg_reg : seg_reg;

    // Status toward the controller.
    always_comb begin
        sts.op             = in_op;
        sts.range_inverted = (last_reg < first_reg);
        sts.table_short    = (count_reg < CW'(2));
        sts.scan_found     = vld_reg && gt_last;
        sts.scan_miss      = vld_reg && !gt_last && (seg_reg == count_m2);
        sts.out_free       = !out_valid_reg || m_tready;
        sts.at_lseg        = (seg_reg == lseg_reg);
    end

    // Next-state logic of all datapath registers.
    always_comb begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        seg_next        = seg_reg;
        fseg_next       = fseg_reg;
        lseg_next       = lseg_reg;
        vld_next        = vld_reg;
        got_first_next  = got_first_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        fi_next         = fi_reg;
        lap1_next       = lap1_reg;
        off_next        = off_reg;
        out_seg_next    = out_seg_reg;
        out_fi_next     = out_fi_reg;
        out_la_next     = out_la_reg;
        out_off_next    = out_off_reg;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        // Accepted input transfer.
        if (cmd.take_item) begin
            case (in_op)
                OP_CLEAR: begin
                    count_next = '0;
                end
                OP_APPEND: begin
                    if (!table_full) begin
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_QUERY: begin
                    first_next = in_first;
                    last_next  = in_last;
                end
                default: begin
                end
            endcase
        end

        // Scan start: first read is the end boundary of segment zero.
        if (cmd.scan_init) begin
            ptr_next       = CW'(1);
            seg_next       = '0;
            vld_next       = 1'b0;
            got_first_next = 1'b0;
        end

        // One boundary issued and one checked per scan cycle.
        if (cmd.scan_step) begin
            if (ptr_reg < count_reg) begin
                vld_next = 1'b1;
                ptr_next = ptr_reg + CW'(1);
            end else begin
                vld_next = 1'b0;
            end
            if (vld_reg) begin
                seg_next = seg_reg + CW'(1);
                if (!got_first_reg && gt_first) begin
                    got_first_next = 1'b1;
                    fseg_next      = seg_reg;
                end
            end
        end

        // Scan hit on the last segment: rewind to the first one.
        if (cmd.emit_init) begin
            fseg_next = fseg_fin;
            seg_next  = fseg_fin;
            ptr_next  = fseg_fin;
            lseg_next = seg_reg;
            off_next  = '0;
        end

        if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + CW'(1);
        end

        if (cmd.load_base) begin
            start_next = rdata;
        end

        // Local bounds of the current segment; the next start is this end.
        if (cmd.emit_calc) begin
            fi_next    = (seg_reg == fseg_reg) ? (first_reg - start_reg) : '0;
            lap1_next  = (seg_reg == lseg_reg) ? (last_reg - start_reg + IW'(1))
                                               : (rdata - start_reg);
            start_next = rdata;
            if (seg_reg != fseg_reg) begin
                off_next = off_reg + out_cnt_reg;
            end
        end

        if (cmd.seg_inc) begin
            seg_next = seg_reg + CW'(1);
        end

        // Load a regular result into the output register.
        if (cmd.emit_put) begin
            out_valid_next  = 1'b1;
            out_seg_next    = SEG_W'(seg_reg);
            out_fi_next     = fi_reg;
            out_la_next     = lap1_reg - IW'(1);
            out_off_next    = off_reg;
            out_cnt_next    = lap1_reg - fi_reg;
            out_status_next = STAT_OK;
            out_last_next   = (seg_reg == lseg_reg);
        end

        // Load an empty or not-found result.
        if (cmd.special_put) begin
            out_valid_next  = 1'b1;
            out_seg_next    = '0;
            out_fi_next     = '0;
            out_la_next     = '0;
            out_off_next    = '0;
            out_cnt_next    = '0;
            out_status_next = cmd.special_status;
            out_last_next   = 1'b1;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            seg_reg       <= '0;
            fseg_reg      <= '0;
            lseg_reg      <= '0;
            vld_reg       <= 1'b0;
            got_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            seg_reg       <= seg_next;
            fseg_reg      <= fseg_next;
            lseg_reg      <= lseg_next;
            vld_reg       <= vld_next;
            got_first_reg <= got_first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        first_reg      <= first_next;
        last_reg       <= last_next;
        start_reg      <= start_next;
        fi_reg         <= fi_next;
        lap1_reg       <= lap1_next;
        off_reg        <= off_next;
        out_seg_reg    <= out_seg_next;
        out_fi_reg     <= out_fi_next;
        out_la_reg     <= out_la_next;
        out_off_reg    <= out_off_next;
        out_cnt_reg    <= out_cnt_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       FIELD_W'(out_cnt_reg),
                       FIELD_W'(out_off_reg),
                       FIELD_W'(out_la_reg),
                       FIELD_W'(out_fi_reg),
                       out_seg_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule
